[hdl/aes_pkg.sv]
// Package with AES types, S-box tables and GF(2^8) helpers.
package aes_pkg;

  localparam int unsigned BLOCK_W = 128;
  localparam int unsigned WORD_W  = 32;

  typedef logic [7:0]   byte_t;
  typedef logic [31:0]  word_t;
  typedef logic [127:0] block_t;

  typedef enum logic [1:0] {
    KS_128 = 2'd0,
    KS_192 = 2'd1,
    KS_256 = 2'd2
  } key_size_t;

  localparam logic [2:0] REG_KEY_SIZE = 3'd0;
  localparam logic [2:0] REG_KEY_W0   = 3'd1;
  localparam logic [2:0] REG_KEY_W1   = 3'd2;
  localparam logic [2:0] REG_KEY_W2   = 3'd3;
  localparam logic [2:0] REG_KEY_W3   = 3'd4;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  // Control from the sequencer to the round datapath.
  typedef struct packed {
    logic load;      // take in the block and XOR the first round key
    logic step;      // run one full round
    logic decrypt;   // inverse cipher
    logic last;      // this round skips MixColumns
  } rnd_ctrl_t;

  function automatic byte_t xtime(input byte_t a);
    xtime = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
  endfunction

  function automatic byte_t sbox(input byte_t x);
    byte_t t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    sbox = t[x];
  endfunction

  function automatic byte_t rev_sbox(input byte_t y);
    byte_t t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    rev_sbox = t[y];
  endfunction

  function automatic word_t sub_word(input word_t w);
    sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage

[hdl/aes_key_mem.sv]
// Key schedule: expands the key into a round-key memory on each expand request.
module aes_key_mem (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 expand,      // restart expansion from the key registers
  input  aes_pkg::key_size_t   key_size,
  input  logic [255:0]         key,
  input  logic [3:0]           rd_round,
  output logic [127:0]         rd_key,      // registered from rd_round
  output logic                 ready,
  output logic [3:0]           num_rounds
);
  import aes_pkg::*;

  // Round keys stored one 32-bit word per entry; four banks give one 128-bit read.
  word_t bank0 [15];
  word_t bank1 [15];
  word_t bank2 [15];
  word_t bank3 [15];

  word_t      hist [8];
  logic [5:0] idx;              // next word to produce
  logic [3:0] pos;              // idx mod nk for the derived words
  byte_t      rc;
  logic       busy;
  logic [3:0] nk;
  logic [5:0] total;

  word_t prev, t, nw;

  always_comb begin
    unique case (key_size)
      KS_128: begin nk = 4'd4; num_rounds = 4'd10; end
      KS_192: begin nk = 4'd6; num_rounds = 4'd12; end
      default: begin nk = 4'd8; num_rounds = 4'd14; end
    endcase
    total = {num_rounds + 4'd1, 2'b00};
  end

  // hist[0] is the newest word, hist[nk-1] the word nk steps back.
  always_comb begin
    prev = hist[0];
    t    = prev;
    if (pos == 4'd0) begin
      t = sub_word({prev[23:0], prev[31:24]}) ^ {rc, 24'h0};
    end else if (nk == 4'd8 && pos == 4'd4) begin
      t = sub_word(prev);
    end
    nw = hist[nk[2:0] - 3'd1] ^ t;
  end

  logic       wr_en;
  logic [5:0] wr_idx;
  word_t      wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ready <= 1'b0;
      idx <= '0;
      pos <= '0;
      rc <= 8'h01;
      wr_en <= 1'b0;
    end else begin
      wr_en <= 1'b0;
      if (expand) begin
        busy  <= 1'b1;
        ready <= 1'b0;
        idx   <= '0;
        pos   <= '0;
        rc    <= 8'h01;
      end else if (busy) begin
        wr_en  <= 1'b1;
        wr_idx <= idx;
        if (idx < {2'b00, nk}) begin
          // Load the key words as they are.
          wr_data <= key[255 - 32*idx[2:0] -: 32];
          for (int i = 7; i > 0; i--) hist[i] <= hist[i-1];
          hist[0] <= key[255 - 32*idx[2:0] -: 32];
        end else begin
          wr_data <= nw;
          for (int i = 7; i > 0; i--) hist[i] <= hist[i-1];
          hist[0] <= nw;
          if (pos == 4'd0) rc <= xtime(rc);
        end
        pos <= (idx < {2'b00, nk}) ? ((idx + 6'd1 == {2'b00, nk}) ? 4'd0 : 4'd0)
             : ((pos + 4'd1 == nk) ? 4'd0 : pos + 4'd1);
        if (idx + 6'd1 == total) begin
          busy  <= 1'b0;
          ready <= 1'b1;
        end
        idx <= idx + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      unique case (wr_idx[1:0])
        2'd0: bank0[wr_idx[5:2]] <= wr_data;
        2'd1: bank1[wr_idx[5:2]] <= wr_data;
        2'd2: bank2[wr_idx[5:2]] <= wr_data;
        default: bank3[wr_idx[5:2]] <= wr_data;
      endcase
    end
    rd_key <= {bank0[rd_round], bank1[rd_round], bank2[rd_round], bank3[rd_round]};
  end

endmodule

[hdl/aes_round.sv]
// One shared AES round unit with the state register.
module aes_round (
  input  logic               clk,
  input  aes_pkg::rnd_ctrl_t ctrl,
  input  logic [127:0]       din,
  input  logic [127:0]       round_key,
  output logic [127:0]       state
);
  import aes_pkg::*;

  byte_t s [16];
  byte_t a [16];
  byte_t b [16];
  byte_t m [16];
  logic [127:0] fwd, inv;

  function automatic byte_t gm(input byte_t x, input byte_t k);
    byte_t x2, x4, x8, p;
    x2 = xtime(x);
    x4 = xtime(x2);
    x8 = xtime(x4);
    p = (k[0] ? x : 8'h00) ^ (k[1] ? x2 : 8'h00) ^ (k[2] ? x4 : 8'h00) ^ (k[3] ? x8 : 8'h00);
    gm = p;
  endfunction

  always_comb begin
    for (int i = 0; i < 16; i++) s[i] = state[127 - 8*i -: 8];
    // Encryption: SubBytes, ShiftRows, MixColumns, AddRoundKey.
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        a[r + 4*c] = sbox(s[r + 4*((c + r) & 3)]);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        m[4*c + r] = xtime(a[4*c + r]) ^ xtime(a[4*c + ((r+1)&3)]) ^ a[4*c + ((r+1)&3)]
                   ^ a[4*c + ((r+2)&3)] ^ a[4*c + ((r+3)&3)];
    for (int i = 0; i < 16; i++)
      fwd[127 - 8*i -: 8] = (ctrl.last ? a[i] : m[i]) ^ round_key[127 - 8*i -: 8];
    // Decryption: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns.
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        b[r + 4*((c + r) & 3)] = rev_sbox(s[r + 4*c]) ^ round_key[127 - 8*(r + 4*((c+r)&3)) -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        byte_t x0, x1, x2, x3, y;
        x0 = b[4*c + r];
        x1 = b[4*c + ((r+1)&3)];
        x2 = b[4*c + ((r+2)&3)];
        x3 = b[4*c + ((r+3)&3)];
        y  = gm(x0, 8'h0e) ^ gm(x1, 8'h0b) ^ gm(x2, 8'h0d) ^ gm(x3, 8'h09);
        inv[127 - 8*(4*c + r) -: 8] = ctrl.last ? x0 : y;
      end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      state <= din ^ round_key;
    end else if (ctrl.step) begin
      state <= ctrl.decrypt ? inv : fwd;
    end
  end

endmodule

[hdl/aes_block_cipher_unit.sv]
// Top level of the iterative AES-128/192/256 ECB block cipher.
// One block is taken when start is high and busy is low; the block then runs
// one round per cycle through a single shared round unit: the first round key
// is fetched from the round-key memory, the block is loaded with it, the Nr
// rounds follow, and done shows the result for exactly one cycle with
// result_high and result_low. The receiver cannot hold a result off. After
// reset or any key register write, the key schedule is rebuilt into the
// round-key memory one word per cycle; busy is high during that time and
// while the expand request is pending, and no request is taken.
// Key size code three acts as 256.
module aes_block_cipher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  output logic        done,
  output logic [63:0] result_high,
  output logic [63:0] result_low,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import aes_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_RUN,
    S_DONE
  } state_t;

  state_t      st;
  logic [1:0]  key_size_reg;
  logic [63:0] key_reg [4];
  logic        dec;
  logic [3:0]  rnd;          // round key index being fetched
  logic [3:0]  cnt;          // rounds done
  logic        expand;
  logic        ks_ready;
  logic [3:0]  nr;
  logic [127:0] rkey, st_q, din;
  rnd_ctrl_t   ctrl;
  key_size_t   ks;

  assign cfg_ready = 1'b1;
  assign ks = key_size_reg[1] ? KS_256 : (key_size_reg[0] ? KS_192 : KS_128);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_size_reg <= '0;
      for (int i = 0; i < 4; i++) key_reg[i] <= '0;
      expand <= 1'b1;
    end else begin
      expand <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_KEY_SIZE: begin key_size_reg <= cfg_data[1:0]; expand <= 1'b1; end
          REG_KEY_W0:   begin key_reg[0] <= cfg_data; expand <= 1'b1; end
          REG_KEY_W1:   begin key_reg[1] <= cfg_data; expand <= 1'b1; end
          REG_KEY_W2:   begin key_reg[2] <= cfg_data; expand <= 1'b1; end
          REG_KEY_W3:   begin key_reg[3] <= cfg_data; expand <= 1'b1; end
          default: ;
        endcase
      end
    end
  end

  aes_key_mem u_key (
    .clk       (clk),
    .rst       (rst),
    .expand    (expand),
    .key_size  (ks),
    .key       ({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
    .rd_round  (rnd),
    .rd_key    (rkey),
    .ready     (ks_ready),
    .num_rounds(nr)
  );

  assign busy = (st != S_IDLE) || !ks_ready || expand;

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      done <= 1'b0;
      rnd  <= '0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      unique case (st)
        S_IDLE: if (start && !busy) begin
          dec <= cmd;
          din <= {block_high, block_low};
          rnd <= cmd ? nr : 4'd0;
          cnt <= '0;
          st  <= S_FETCH;
        end
        S_FETCH: begin
          st  <= S_RUN;
          rnd <= dec ? rnd - 4'd1 : rnd + 4'd1;
        end
        S_RUN: begin
          cnt <= cnt + 4'd1;
          rnd <= dec ? rnd - 4'd1 : rnd + 4'd1;
          if (cnt == nr) begin
            st   <= S_IDLE;
            done <= 1'b1;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // cnt 0 in S_RUN is the load with the first key, then rounds 1..nr.
  always_comb begin
    ctrl.load    = (st == S_RUN) && (cnt == 4'd0);
    ctrl.step    = (st == S_RUN) && (cnt != 4'd0);
    ctrl.decrypt = dec;
    ctrl.last    = (cnt == nr);
  end

  aes_round u_round (
    .clk      (clk),
    .ctrl     (ctrl),
    .din      (din),
    .round_key(rkey),
    .state    (st_q)
  );

  assign result_high = st_q[127:64];
  assign result_low  = st_q[63:0];

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");
  a_busy_run: assert property (@(posedge clk) disable iff (rst) (st == S_RUN) |-> busy)
    else $error("not busy while running");
  a_fetch_after_start: assert property (@(posedge clk) disable iff (rst)
    (st == S_FETCH) |-> $past(start && !busy))
    else $error("block started without a request");

endmodule

[bench/aes_block_cipher_unit_tb.sv]
// Self-checking testbench for the AES ECB block cipher unit.
module aes_block_cipher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aes_pkg::*;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } aes_block_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        cmd = CMD_ENCRYPT;
  logic [63:0] block_high = '0;
  logic [63:0] block_low = '0;
  logic        done;
  logic [63:0] result_high;
  logic [63:0] result_low;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_KEY_SIZE;
  logic [63:0] cfg_data = '0;

  // Shadow copy of the key registers as the predictor sees them.
  logic [1:0]  mdl_key_size;
  logic [63:0] mdl_key [4];

  aes_block_t  expected_blocks [$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          timed_out = 1'b0;

  aes_block_cipher_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .block_high(block_high), .block_low(block_low), .done(done),
    .result_high(result_high), .result_low(result_low),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // GF(2^8) multiply, written out so that the predictor does not lean on
  // the package helpers.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
    end
    return p;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] x);
    logic [7:0] r;
    r = 8'h01;
    for (int i = 0; i < 254; i++) r = gf_mul(r, x);
    return r;
  endfunction

  function automatic logic [7:0] rol8(input logic [7:0] x, input int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  // S-box tables are built once from the field inverse and the affine map.
  logic [7:0] fwd_sub [256];
  logic [7:0] inv_sub [256];

  task automatic build_sub_tables();
    logic [7:0] b;
    for (int x = 0; x < 256; x++) begin
      b = gf_inv(8'(x));
      fwd_sub[x] = b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
    end
    for (int x = 0; x < 256; x++) inv_sub[fwd_sub[x]] = 8'(x);
  endtask

  function automatic logic [31:0] sub_w(input logic [31:0] w);
    return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
  endfunction

  // Computes the cipher output for one request under the shadow key.
  function automatic aes_block_t aes_cipher(input logic dec, input logic [63:0] hi,
                                            input logic [63:0] lo);
    logic [31:0] w [60];
    logic [7:0]  s [16];
    logic [7:0]  t [16];
    logic [7:0]  col [4];
    logic [7:0]  rc;
    logic [31:0] tmp;
    logic [7:0]  m [4];
    int nk, nr, rd;
    aes_block_t res;
    rc = 8'h01;
    if (mdl_key_size[1]) begin nk = 8; nr = 14; end
    else if (mdl_key_size[0]) begin nk = 6; nr = 12; end
    else begin nk = 4; nr = 10; end
    for (int i = 0; i < nk; i++)
      w[i] = i[0] ? mdl_key[i >> 1][31:0] : mdl_key[i >> 1][63:32];
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      tmp = w[i - 1];
      if (i % nk == 0) begin
        tmp = sub_w({tmp[23:0], tmp[31:24]}) ^ {rc, 24'h0};
        rc = rc[7] ? ((rc << 1) ^ 8'h1b) : (rc << 1);
      end else if (nk > 6 && i % nk == 4) begin
        tmp = sub_w(tmp);
      end
      w[i] = w[i - nk] ^ tmp;
    end
    for (int i = 0; i < 8; i++) begin
      s[i] = hi[63 - 8 * i -: 8];
      s[8 + i] = lo[63 - 8 * i -: 8];
    end
    if (dec) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else m = '{8'h02, 8'h03, 8'h01, 8'h01};
    rd = dec ? nr : 0;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) s[4 * c + r] ^= w[4 * rd + c][31 - 8 * r -: 8];
    for (int k = 1; k <= nr; k++) begin
      rd = dec ? nr - k : k;
      // Byte substitution and row shift commute, so both directions share this order.
      for (int i = 0; i < 16; i++) s[i] = dec ? inv_sub[s[i]] : fwd_sub[s[i]];
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          if (dec) t[r + 4 * ((c + r) & 3)] = s[r + 4 * c];
          else t[r + 4 * c] = s[r + 4 * ((c + r) & 3)];
      s = t;
      // Forward rounds mix before the key; inverse rounds add the key first.
      for (int pass = 0; pass < 2; pass++) begin
        if ((pass == 0) == dec) begin
          for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) s[4 * c + r] ^= w[4 * rd + c][31 - 8 * r -: 8];
        end else if (k != nr) begin
          for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) col[r] = s[4 * c + r];
            for (int r = 0; r < 4; r++) begin
              s[4 * c + r] = '0;
              for (int j = 0; j < 4; j++) s[4 * c + r] ^= gf_mul(m[(j - r) & 3], col[j]);
            end
          end
        end
      end
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63 - 8 * i -: 8] = s[i];
      res.lo[63 - 8 * i -: 8] = s[8 + i];
    end
    return res;
  endfunction

  // Sender burst state shared by all tests.
  int unsigned burst_left = 0;

  task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    cmd <= op;
    block_high <= hi;
    block_low <= lo;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_blocks.insert(expected_blocks.size(), aes_cipher(op, hi, lo));
    @(negedge clk);
    start <= 1'b0;
    @(negedge clk);
  endtask

  // Waits for every outstanding result, then for any trailing activity.
  task automatic drain();
    while (expected_blocks.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register writes happen only while nothing is outstanding.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    drain();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_KEY_SIZE) mdl_key_size = val[1:0];
    else if (idx <= REG_KEY_W3) mdl_key[idx - 1] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_key(input logic [1:0] ks, input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
    write_reg(REG_KEY_SIZE, {62'h0, ks});
    write_reg(REG_KEY_W0, k0);
    write_reg(REG_KEY_W1, k1);
    write_reg(REG_KEY_W2, k2);
    write_reg(REG_KEY_W3, k3);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Known-answer vectors per key size, field extremes under zero and all-ones keys.
  task automatic test_directed();
    send_block(CMD_ENCRYPT, '0, '0);
    send_block(CMD_DECRYPT, '0, '0);
    send_block(CMD_ENCRYPT, '1, '1);
    send_block(CMD_DECRYPT, '1, '1);
    load_key(KS_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
    send_block(CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(CMD_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    load_key(KS_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617, '1);
    send_block(CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(CMD_DECRYPT, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
    load_key(KS_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
             64'h18191a1b1c1d1e1f);
    send_block(CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(CMD_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
    // Size code three behaves as a 256-bit key.
    write_reg(REG_KEY_SIZE, 64'h3);
    send_block(CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    // An index past the register list must leave every key register alone.
    write_reg(3'd5, '1);
    write_reg(3'd7, 64'h0);
    send_block(CMD_DECRYPT, '1, '0);
    load_key(KS_128, '1, '1, '1, '1);
    send_block(CMD_ENCRYPT, '0, '1);
    send_block(CMD_DECRYPT, '1, '0);
  endtask

  // Random blocks under a series of random keys of every size.
  task automatic test_random_blocks();
    logic [1:0] ks;
    for (int ph = 0; ph < 11; ph++) begin
      ks = (ph % 4 == 3) ? 2'd3 : 2'(ph % 3);
      load_key(ks, rand64(), rand64(), rand64(), rand64());
      for (int n = 0; n < 48; n++) begin
        send_block(logic'($urandom_range(0, 1)), rand64(), rand64());
        // Hold off now and then until everything has come back.
        if (n == 20) drain();
      end
    end
  endtask

  initial begin
    mdl_key_size = KS_128;
    foreach (mdl_key[i]) mdl_key[i] = '0;
    build_sub_tables();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_blocks();
    drain();
    if (mismatches == 0 && !timed_out) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Each strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    aes_block_t exp_blk;
    if (!rst && done) begin
      if (expected_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h", result_high, result_low);
      end else begin
        exp_blk = expected_blocks.pop_front();
        if (result_high !== exp_blk.hi || result_low !== exp_blk.lo) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h %h, got %h %h",
                     exp_blk.hi, exp_blk.lo, result_high, result_low);
        end
      end
    end
  end

  // Watchdog: ends the run after too long without any accepted handshake.
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        timed_out = 1'b1;
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule
